[rtl/undirected_max_flow_core_assert.svh]
`ifndef UNDIRECTED_MAX_FLOW_CORE_ASSERT_SVH
`define UNDIRECTED_MAX_FLOW_CORE_ASSERT_SVH

// same-cycle implication
`define UMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/umf_pkg.sv]
package umf_pkg;

  localparam int unsigned MAX_NODES_DEF = 128;
  localparam int unsigned ENTRY_W = 24;
  localparam int unsigned FLOW_W = 31;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_SINK       = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD_ENTRY = 2'd0,
    ALU_ADD_FLOW  = 2'd1,
    ALU_SUB       = 2'd2,
    ALU_MIN       = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic               used;
    logic [ENTRY_W-1:0] val;
  } entry_t;

endpackage

[rtl/umf_alu.sv]
module umf_alu (
  input  umf_pkg::alu_op_e             op_i,
  input  logic [umf_pkg::FLOW_W-1:0]   a_i,
  input  logic [umf_pkg::FLOW_W-1:0]   b_i,
  output logic [umf_pkg::FLOW_W-1:0]   y_o
);

  logic [umf_pkg::FLOW_W:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, b_i};

  always_comb begin
    case (op_i)
      umf_pkg::ALU_ADD_ENTRY: begin
        y_o = (sum > {1'b0, umf_pkg::FLOW_W'(umf_pkg::ENTRY_MAX)}) ?
              umf_pkg::FLOW_W'(umf_pkg::ENTRY_MAX) : sum[umf_pkg::FLOW_W-1:0];
      end
      umf_pkg::ALU_ADD_FLOW: begin
        y_o = sum[umf_pkg::FLOW_W] ? umf_pkg::FLOW_MAX : sum[umf_pkg::FLOW_W-1:0];
      end
      umf_pkg::ALU_SUB: y_o = a_i - b_i;
      umf_pkg::ALU_MIN: y_o = (b_i < a_i) ? b_i : a_i;
      default: y_o = a_i;
    endcase
  end

endmodule

[rtl/undirected_max_flow_core.sv]
// edge item: two read-modify-writes of the capacity memory; an empty item skips them
// last item: the flow search runs a breadth-first search per path, reading the capacity
//   of each scanned node pair, then walks the path hops once to find the bottleneck and
//   once more to update both directions; the result comes as a clearing pass starts
// one item at a time; busy_o stays high until the item is fully done
// reset is asynchronous active low; after reset a clearing pass over the capacity memory runs
// results last one cycle on result_valid_o and cannot be stalled
`include "undirected_max_flow_core_assert.svh"

module undirected_max_flow_core #(
  parameter int unsigned MAX_NODES = umf_pkg::MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        has_edge_i,
  input  logic [6:0]  node_a_i,
  input  logic [6:0]  node_b_i,
  input  logic [15:0] capacity_i,
  input  logic        last_i,
  output logic        result_valid_o,
  output logic [30:0] bandwidth_o,
  output logic        bad_config_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned NC = NW + 1;
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned FW = umf_pkg::FLOW_W;
  localparam int unsigned EW = umf_pkg::ENTRY_W;

  typedef enum logic [19:0] {
    S_CLEAR    = 20'h00001,
    S_IDLE     = 20'h00002,
    S_LD_RA    = 20'h00004,
    S_LD_WA    = 20'h00008,
    S_LD_RB    = 20'h00010,
    S_LD_WB    = 20'h00020,
    S_DECIDE   = 20'h00040,
    S_BFS_INIT = 20'h00080,
    S_POP      = 20'h00100,
    S_POP_U    = 20'h00200,
    S_SCAN     = 20'h00400,
    S_SCAN_CHK = 20'h00800,
    S_PM_PAR   = 20'h01000,
    S_PM_MEM   = 20'h02000,
    S_PM_CMP   = 20'h04000,
    S_UP_PAR   = 20'h08000,
    S_UP_RDF   = 20'h10000,
    S_UP_WRF   = 20'h20000,
    S_UP_WRB   = 20'h40000,
    S_TOT      = 20'h80000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] ncount_q;
  logic [6:0] src_q, dst_q;

  logic       edge_q, last_q;
  logic [6:0] a_q, b_q;
  logic [15:0] cap_q;

  umf_pkg::entry_t mem_q [DEPTH];
  umf_pkg::entry_t rd_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  umf_pkg::entry_t mem_wdata;

  logic [NW-1:0] par_q [MAX_NODES];
  logic [NW-1:0] prd_q;
  logic          par_we, par_re;
  logic [NW-1:0] par_waddr, par_raddr, par_wdata;

  logic [NW-1:0] que_q [MAX_NODES];
  logic [NW-1:0] qrd_q;
  logic          que_we, que_re;
  logic [NW-1:0] que_waddr, que_raddr, que_wdata;

  logic [MAX_NODES-1:0] visited_q;
  logic [NC-1:0] head_q, tail_q, v_q;
  logic [NW-1:0] u_q, pv_q;
  logic [EW-1:0] m_q;
  logic          first_q;
  logic [FW-1:0] total_q, bw_q;
  logic          bad_q, valid_q;
  logic [AW-1:0] clr_q;

  umf_pkg::alu_op_e alu_op;
  logic [FW-1:0]    alu_a, alu_b, alu_y;

  logic [NW-1:0] src_n, dst_n, a_n, b_n, vi;
  logic [NC-1:0] n_lim;
  logic          edge_ok, term_ok, hit;

  assign src_n = NW'(src_q);
  assign dst_n = NW'(dst_q);
  assign a_n   = NW'(a_q);
  assign b_n   = NW'(b_q);
  assign vi    = v_q[NW-1:0];
  assign n_lim = (32'(ncount_q) > MAX_NODES) ? NC'(MAX_NODES) : NC'(ncount_q);
  assign edge_ok = edge_q && (32'(a_q) < MAX_NODES) && (32'(b_q) < MAX_NODES);
  assign term_ok = (32'(src_q) < MAX_NODES) && (32'(dst_q) < MAX_NODES);
  assign hit = !visited_q[vi] && (rd_q.val != '0);

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = valid_q;
  assign bandwidth_o    = bw_q;
  assign bad_config_o   = bad_q;

  umf_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  always_comb begin
    alu_op = umf_pkg::ALU_ADD_ENTRY;
    alu_a  = FW'(rd_q.val);
    alu_b  = FW'(cap_q);
    case (state_q)
      S_PM_CMP: begin
        alu_op = umf_pkg::ALU_MIN;
        alu_a  = FW'(m_q);
        alu_b  = FW'(rd_q.val);
      end
      S_UP_WRF: begin
        alu_op = umf_pkg::ALU_SUB;
        alu_b  = FW'(m_q);
      end
      S_UP_WRB: begin
        alu_a = first_q ? '0 : FW'(rd_q.val);
        alu_b = FW'(m_q);
      end
      S_TOT: begin
        alu_op = umf_pkg::ALU_ADD_FLOW;
        alu_a  = total_q;
        alu_b  = FW'(m_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {a_n, b_n};
    mem_raddr = {a_n, b_n};
    mem_wdata = '{used: rd_q.used, val: alu_y[EW-1:0]};
    par_we    = 1'b0;
    par_re    = 1'b0;
    par_waddr = vi;
    par_raddr = pv_q;
    par_wdata = u_q;
    que_we    = 1'b0;
    que_re    = 1'b0;
    que_waddr = tail_q[NW-1:0];
    que_raddr = head_q[NW-1:0];
    que_wdata = vi;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = S_LD_RA;
      end
      S_LD_RA: begin
        if (edge_ok) begin
          mem_re  = 1'b1;
          state_d = S_LD_WA;
        end else begin
          state_d = last_q ? S_DECIDE : S_IDLE;
        end
      end
      S_LD_WA: begin
        mem_we  = 1'b1;
        state_d = S_LD_RB;
      end
      S_LD_RB: begin
        mem_re    = 1'b1;
        mem_raddr = {b_n, a_n};
        state_d   = S_LD_WB;
      end
      S_LD_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {b_n, a_n};
        state_d   = last_q ? S_DECIDE : S_IDLE;
      end
      S_DECIDE: begin
        state_d = (src_q != dst_q && term_ok) ? S_BFS_INIT : S_CLEAR;
      end
      S_BFS_INIT: begin
        que_we    = 1'b1;
        que_waddr = '0;
        que_wdata = src_n;
        state_d   = S_POP;
      end
      S_POP: begin
        if (visited_q[dst_n]) begin
          state_d = S_PM_PAR;
        end else if (head_q < tail_q) begin
          que_re  = 1'b1;
          state_d = S_POP_U;
        end else begin
          state_d = S_CLEAR;
        end
      end
      S_POP_U: state_d = S_SCAN;
      S_SCAN: begin
        if (v_q < n_lim) begin
          mem_re    = 1'b1;
          mem_raddr = {u_q, vi};
          state_d   = S_SCAN_CHK;
        end else begin
          state_d = S_POP;
        end
      end
      S_SCAN_CHK: begin
        if (hit) begin
          par_we = 1'b1;
          que_we = 1'b1;
        end
        state_d = (hit && vi == dst_n) ? S_POP : S_SCAN;
      end
      S_PM_PAR: begin
        par_re  = 1'b1;
        state_d = S_PM_MEM;
      end
      S_PM_MEM: begin
        mem_re    = 1'b1;
        mem_raddr = {prd_q, pv_q};
        state_d   = S_PM_CMP;
      end
      S_PM_CMP: begin
        state_d = (u_q == src_n) ? S_UP_PAR : S_PM_PAR;
      end
      S_UP_PAR: begin
        par_re  = 1'b1;
        state_d = S_UP_RDF;
      end
      S_UP_RDF: begin
        mem_re    = 1'b1;
        mem_raddr = {prd_q, pv_q};
        state_d   = S_UP_WRF;
      end
      S_UP_WRF: begin
        mem_we    = 1'b1;
        mem_waddr = {u_q, pv_q};
        mem_wdata = '{used: 1'b1, val: alu_y[EW-1:0]};
        mem_re    = 1'b1;
        mem_raddr = {pv_q, u_q};
        state_d   = S_UP_WRB;
      end
      S_UP_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = {pv_q, u_q};
        mem_wdata = '{used: 1'b1, val: alu_y[EW-1:0]};
        state_d   = (u_q == src_n) ? S_TOT : S_UP_PAR;
      end
      S_TOT: state_d = S_BFS_INIT;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_raddr];
    if (par_we) par_q[par_waddr] <= par_wdata;
    if (par_re) prd_q <= par_q[par_raddr];
    if (que_we) que_q[que_waddr] <= que_wdata;
    if (que_re) qrd_q <= que_q[que_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      edge_q <= has_edge_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      cap_q  <= capacity_i;
      last_q <= last_i;
    end
    first_q <= !rd_q.used;
    case (state_q)
      S_BFS_INIT: begin
        head_q <= '0;
        tail_q <= NC'(1);
      end
      S_POP: begin
        if (visited_q[dst_n]) begin
          pv_q <= dst_n;
          m_q  <= umf_pkg::ENTRY_MAX;
        end else begin
          head_q <= head_q + NC'(1);
        end
      end
      S_POP_U: begin
        u_q <= qrd_q;
        v_q <= '0;
      end
      S_SCAN_CHK: begin
        v_q <= v_q + NC'(1);
        if (hit) tail_q <= tail_q + NC'(1);
      end
      S_PM_MEM, S_UP_RDF: u_q <= prd_q;
      S_PM_CMP: begin
        m_q  <= alu_y[EW-1:0];
        pv_q <= (u_q == src_n) ? dst_n : u_q;
      end
      S_UP_WRB: pv_q <= u_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      ncount_q  <= 8'd2;
      src_q     <= 7'd0;
      dst_q     <= 7'd1;
      visited_q <= '0;
      total_q   <= '0;
      bw_q      <= '0;
      bad_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_DECIDE && !(src_q != dst_q && term_ok)) ||
                 (state_q == S_POP && !visited_q[dst_n] && !(head_q < tail_q));
      if (cfg_valid_i) begin
        case (cfg_index_i)
          umf_pkg::REG_NODE_COUNT: ncount_q <= cfg_data_i;
          umf_pkg::REG_SOURCE:     src_q    <= cfg_data_i[6:0];
          umf_pkg::REG_SINK:       dst_q    <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      case (state_q)
        S_DECIDE: begin
          total_q <= '0;
          if (!(src_q != dst_q && term_ok)) begin
            bw_q    <= '0;
            bad_q   <= (src_q == dst_q);
            clr_q   <= '0;
          end
        end
        S_BFS_INIT: begin
          visited_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src_n;
        end
        S_POP: begin
          if (!visited_q[dst_n] && !(head_q < tail_q)) begin
            bw_q    <= total_q;
            bad_q   <= 1'b0;
            clr_q   <= '0;
          end
        end
        S_SCAN_CHK: begin
          if (hit) visited_q[vi] <= 1'b1;
        end
        S_TOT: total_q <= alu_y;
        default: ;
      endcase
    end
  end

  `UMF_ASSERT_NOW(a_result_busy, result_valid_o, busy_o, "result outside a busy phase")
  `UMF_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted item did not go busy")
  `UMF_ASSERT_NOW(a_bad_zero, result_valid_o && bad_config_o, bandwidth_o == '0,
    "error result with nonzero flow")
  `UMF_ASSERT_NOW(a_src_visited, state_q == S_SCAN || state_q == S_SCAN_CHK,
    visited_q[src_n], "source not marked during search")

endmodule
